>>> rtl/core/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync / length / checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // largest payload the buffer holds
  localparam int unsigned MaxPayload = 64;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  // framing constants
  localparam logic [ByteW-1:0] SyncByte = 8'hAA;
  localparam logic [ByteW-1:0] ZeroByte = 8'h00;

  // sequencer states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } slcd_state_e;

  // request from the sequencer to load the output register
  typedef struct packed {
    logic            load;
    logic            present;
    logic            last;
    logic [LenW-1:0] length;
  } slcd_load_t;

endpackage

>>> rtl/core/slcd_ram.sv
// ----------------------------------------------------------------------------
// slcd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/slcd_ctrl.sv
// ----------------------------------------------------------------------------
// slcd_ctrl
// Frame sequencer: parses sync, length and payload bytes with one shared
// 8-bit adder for the running sum and the checksum test, writes the payload
// buffer, and steps through the buffer to read out a verified frame.
// ----------------------------------------------------------------------------
module slcd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [slcd_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         out_free_i,
  output logic                         ram_we_o,
  output logic [slcd_pkg::AddrW-1:0]   ram_waddr_o,
  output logic [slcd_pkg::AddrW-1:0]   ram_raddr_o,
  output slcd_pkg::slcd_load_t         load_o
);

  import slcd_pkg::*;

  slcd_state_e      state_q, state_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] sum_q, sum_d;

  logic             in_beat;
  logic [ByteW-1:0] sum_plus;
  logic [LenW-1:0]  fill_inc;
  logic             read_last;

  // shared adder: accumulation and checksum test (sum + byte wraps to zero)
  assign sum_plus  = sum_q + rx_byte_i;
  assign fill_inc  = fill_q + LenW'(1);
  assign read_last = (fill_inc == exp_q);
  assign in_beat   = in_valid_i && in_ready_o;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      exp_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
    end
  end

  // next state and outputs
  always_comb begin
    state_d        = state_q;
    exp_d          = exp_q;
    fill_d         = fill_q;
    sum_d          = sum_q;
    in_ready_o     = 1'b0;
    ram_we_o       = 1'b0;
    ram_waddr_o    = fill_q[AddrW-1:0];
    ram_raddr_o    = fill_q[AddrW-1:0];
    load_o.load    = 1'b0;
    load_o.present = 1'b0;
    load_o.last    = 1'b0;
    load_o.length  = exp_q;

    unique case (state_q)
      ST_HUNT: begin
        in_ready_o = 1'b1;
        if (in_beat && (rx_byte_i == SyncByte)) begin
          state_d = ST_LEN_HI;
          exp_d   = '0;
          fill_d  = '0;
          sum_d   = '0;
        end
      end
      ST_LEN_HI: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          sum_d   = sum_plus;
          state_d = (rx_byte_i != ZeroByte) ? ST_HUNT : ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          sum_d  = sum_plus;
          fill_d = '0;
          if (rx_byte_i > ByteW'(MaxPayload)) begin
            state_d = ST_HUNT;
          end else begin
            exp_d   = rx_byte_i[LenW-1:0];
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          if (fill_q < exp_q) begin
            // payload byte into the buffer
            ram_we_o = 1'b1;
            fill_d   = fill_inc;
            sum_d    = sum_plus;
          end else if (sum_plus == ZeroByte) begin
            // checksum good
            fill_d  = '0;
            state_d = (exp_q == '0) ? ST_EMPTY : ST_READ;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free_i) begin
          load_o.load    = 1'b1;
          load_o.present = 1'b1;
          load_o.last    = read_last;
          fill_d         = fill_inc;
          state_d        = read_last ? ST_HUNT : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (out_free_i) begin
          load_o.load    = 1'b1;
          load_o.last    = 1'b1;
          state_d        = ST_HUNT;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // input is never taken while a result is being loaded
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && load_o.load))
    else $error("input accepted during readout");

  // buffer fill never runs past the frame length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (fill_q <= exp_q))
    else $error("fill count beyond frame length");

  // frame length stays within the buffer
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q <= LenW'(MaxPayload))
    else $error("frame length beyond buffer size");

  // an empty-frame result carries no byte and is the last one
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_o.load && !load_o.present) |-> (load_o.last && (exp_q == '0)))
    else $error("malformed empty-frame result");
`endif

endmodule

>>> rtl/core/sync_length_checksum_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Sync / length / checksum deframer with a buffered payload burst.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while a frame is being parsed
// (sync 0xAA, length high, length low, payload, checksum). After a checksum
// byte that matches, input is held off while the payload is read back out of
// the 64-byte buffer: each result takes a buffer read (ST_READ) and then a
// load into the output register (ST_LOAD), which waits while the output is
// stalled; an empty frame gives one result with no byte (ST_EMPTY).
// The output register lets the next frame start while the last result of the
// previous one still waits to be taken. No clearing pass is needed at reset.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [slcd_pkg::ByteW-1:0]  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slcd_pkg::ByteW-1:0]  payload_byte_o,
  output logic                        byte_present_o,
  output logic [slcd_pkg::LenW-1:0]   frame_length_o,
  output logic                        last_byte_o
);

  import slcd_pkg::*;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  slcd_load_t       load;
  logic             out_free;

  logic             out_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             present_q;
  logic [LenW-1:0]  length_q;
  logic             last_q;

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  slcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_free_i  (out_free),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr),
    .load_o      (load)
  );

  // payload buffer
  slcd_ram #(
    .Width (ByteW),
    .Depth (MaxPayload)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load.load) begin
      byte_q    <= load.present ? ram_rdata : ZeroByte;
      present_q <= load.present;
      length_q  <= load.length;
      last_q    <= load.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = byte_q;
  assign byte_present_o = present_q;
  assign frame_length_o = length_q;
  assign last_byte_o    = last_q;

endmodule
